// ----- sv/ptbg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ptbg_pkg;

    localparam int IDX_W       = 3;
    localparam int PERIOD_W    = 24;
    localparam int MAX_RESULTS = 8;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_TICK  = 1'b1;
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [IDX_W-1:0]    timer_index;
        logic [PERIOD_W-1:0] period;
    } req_t;

    typedef struct packed {
        logic                kind;
        logic [IDX_W-1:0]    fired_index;
        logic [PERIOD_W-1:0] base_quantum;
        logic                last;
    } rsp_t;

endpackage

`default_nettype wire

// ----- sv/ptbg_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ptbg_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 24
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DW-1:0]    rd_data_reg;

    // entries never written read back as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/ptbg_gcd.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ptbg_gcd #(
    parameter int W = 24
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] a_in,
    input  wire logic [W-1:0] b_in,
    output logic              busy,
    output logic              done,
    output logic      [W-1:0] result
);

    localparam int KW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [KW-1:0] k_reg;
    logic [W-1:0]  result_reg;

    // binary gcd, one reduction step per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            a_reg      <= '0;
            b_reg      <= '0;
            k_reg      <= '0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                a_reg    <= a_in;
                b_reg    <= b_in;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (a_reg == '0)
                begin
                    result_reg <= b_reg << k_reg;
                    done_reg   <= 1'b1;
                    busy_reg   <= 1'b0;
                end
                else if (b_reg == '0)
                begin
                    result_reg <= a_reg << k_reg;
                    done_reg   <= 1'b1;
                    busy_reg   <= 1'b0;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                    k_reg <= k_reg + KW'(1);
                end
                else if (!a_reg[0])
                begin
                    a_reg <= a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_reg <= b_reg >> 1;
                end
                else if (a_reg >= b_reg)
                begin
                    a_reg <= a_reg - b_reg;
                end
                else
                begin
                    b_reg <= b_reg - a_reg;
                end
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- sv/periodic_timer_bank_gcd_tick.sv -----
// bank of periodic timers sharing one base tick quantum
// request channel (req_valid / req_stall / req_data): a load request sets the
// period of one timer and restarts it; a tick request stands for one quantum
// of elapsed time. one request is worked on at a time, req_stall is high
// from acceptance until the request is finished, and the next request can be
// taken in the cycle after that.
// result channel (rsp_valid / rsp_stall / rsp_data): a load gives one
// acknowledge carrying the new quantum, or the old one for an out-of-bank
// index; a tick gives one result per fired timer (lowest indices first, at
// most eight reported), last on the final one, and nothing when no timer
// fires or no timer is enabled.
// a tick walks the timers, each with a memory read and then an update,
// plus a push step per reported firing and a finish step; a tick with no
// timer enabled is taken without any stall. a load reads and evaluates
// every timer, runs the binary gcd unit per enabled period, then acknowledges.
// a stalled receiver holds the sequencer only when a new result must go out
// and the output register is still full.
// reset clears both memories at once through per-entry valid bits and sets
// the quantum to zero; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_bank_gcd_tick
    import ptbg_pkg::*;
#(
    parameter int NUM_TIMERS = 8,
    parameter int TIME_WIDTH = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req_data,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp_data
);

    localparam int              AW       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [AW-1:0]   LAST_IDX = AW'(NUM_TIMERS - 1);
    localparam int              CW       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_GREAD,
        S_GEVAL,
        S_GWAIT,
        S_ACK,
        S_TREAD,
        S_TEVAL,
        S_PUSH,
        S_FINISH
    } state_t;

    state_t                state_reg;
    logic [AW-1:0]         idx_reg;
    logic [TIME_WIDTH-1:0] gcd_acc_reg;
    logic [TIME_WIDTH-1:0] quantum_reg;
    logic [CW-1:0]         count_reg;
    logic                  pend_valid_reg;
    logic [AW-1:0]         pend_idx_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_data_reg;

    logic                  req_accept;
    logic                  load_hit;
    logic [AW-1:0]         load_addr;
    logic [TIME_WIDTH-1:0] load_per;
    logic                  slot_free;
    logic                  last_idx;
    logic                  rd_en;
    logic [TIME_WIDTH-1:0] per_rd;
    logic [TIME_WIDTH-1:0] rem_rd;
    logic                  timer_on;
    logic                  timer_fire;
    logic                  fire_report;
    logic                  rem_wr_en;
    logic [AW-1:0]         rem_wr_addr;
    logic [TIME_WIDTH-1:0] rem_wr_data;
    logic                  gcd_start;
    logic                  gcd_busy;
    logic                  gcd_done;
    logic [TIME_WIDTH-1:0] gcd_result;

    assign req_accept = req_valid && (state_reg == S_IDLE);
    assign load_hit   = req_accept && (req_data.req_type == REQ_LOAD)
                        && (32'(req_data.timer_index) < NUM_TIMERS);
    assign load_addr  = AW'(req_data.timer_index);
    // period masked or zero-extended to the time width
    assign load_per   = TIME_WIDTH'(req_data.period);
    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign last_idx   = (idx_reg == LAST_IDX);

    // both memories are read at the scan index; the write of an entry always
    // lands before the next read of it, so no forwarding is needed
    assign rd_en       = (state_reg == S_GREAD) || (state_reg == S_TREAD);
    assign timer_on    = (per_rd != '0);
    assign timer_fire  = timer_on && (rem_rd <= quantum_reg);
    assign fire_report = timer_fire && (count_reg < CW'(MAX_RESULTS));

    // remaining time: restart on load, count down or reload on tick
    assign rem_wr_en   = load_hit || ((state_reg == S_TEVAL) && timer_on);
    assign rem_wr_addr = load_hit ? load_addr : idx_reg;
    assign rem_wr_data = load_hit   ? load_per :
                         timer_fire ? per_rd   : (rem_rd - quantum_reg);

    assign gcd_start = (state_reg == S_GEVAL) && timer_on;

    ptbg_ram #(
        .DEPTH (NUM_TIMERS),
        .AW    (AW),
        .DW    (TIME_WIDTH)
    ) u_period_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_hit),
        .wr_addr (load_addr),
        .wr_data (load_per),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (per_rd)
    );

    ptbg_ram #(
        .DEPTH (NUM_TIMERS),
        .AW    (AW),
        .DW    (TIME_WIDTH)
    ) u_remain_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rem_wr_en),
        .wr_addr (rem_wr_addr),
        .wr_data (rem_wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rem_rd)
    );

    ptbg_gcd #(
        .W (TIME_WIDTH)
    ) u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gcd_start),
        .a_in   (gcd_acc_reg),
        .b_in   (per_rd),
        .busy   (gcd_busy),
        .done   (gcd_done),
        .result (gcd_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            gcd_acc_reg    <= '0;
            quantum_reg    <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_data_reg   <= '0;
        end
        else
        begin
            // result taken by the receiver
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg        <= '0;
                    gcd_acc_reg    <= '0;
                    count_reg      <= '0;
                    pend_valid_reg <= 1'b0;
                    if (req_accept)
                    begin
                        if (req_data.req_type == REQ_LOAD)
                        begin
                            // out-of-bank index: acknowledge with the old quantum
                            state_reg <= load_hit ? S_GREAD : S_ACK;
                        end
                        else if (quantum_reg != '0)
                        begin
                            state_reg <= S_TREAD;
                        end
                    end
                end

                // gcd sweep over all periods
                S_GREAD:
                begin
                    state_reg <= S_GEVAL;
                end

                S_GEVAL:
                begin
                    if (timer_on)
                    begin
                        state_reg <= S_GWAIT;
                    end
                    else if (last_idx)
                    begin
                        quantum_reg <= gcd_acc_reg;
                        state_reg   <= S_ACK;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= S_GREAD;
                    end
                end

                S_GWAIT:
                begin
                    if (gcd_done)
                    begin
                        gcd_acc_reg <= gcd_result;
                        if (last_idx)
                        begin
                            quantum_reg <= gcd_result;
                            state_reg   <= S_ACK;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= S_GREAD;
                        end
                    end
                end

                S_ACK:
                begin
                    if (slot_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_data_reg  <= '{kind:         KIND_ACK,
                                           fired_index:  '0,
                                           base_quantum: PERIOD_W'(quantum_reg),
                                           last:         1'b1};
                        state_reg     <= S_IDLE;
                    end
                end

                // tick scan, one timer per read and update
                S_TREAD:
                begin
                    state_reg <= S_TEVAL;
                end

                S_TEVAL:
                begin
                    if (fire_report)
                    begin
                        state_reg <= S_PUSH;
                    end
                    else if (last_idx)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= S_TREAD;
                    end
                end

                // the latest firing is held back until we know if it is the last
                S_PUSH:
                begin
                    if (!pend_valid_reg || slot_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            rsp_valid_reg <= 1'b1;
                            rsp_data_reg  <= '{kind:         KIND_FIRE,
                                               fired_index:  IDX_W'(pend_idx_reg),
                                               base_quantum: PERIOD_W'(quantum_reg),
                                               last:         1'b0};
                        end
                        pend_valid_reg <= 1'b1;
                        pend_idx_reg   <= idx_reg;
                        count_reg      <= count_reg + CW'(1);
                        if (last_idx)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= S_TREAD;
                        end
                    end
                end

                S_FINISH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (slot_free)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_data_reg   <= '{kind:         KIND_FIRE,
                                            fired_index:  IDX_W'(pend_idx_reg),
                                            base_quantum: PERIOD_W'(quantum_reg),
                                            last:         1'b1};
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef SYNTH
    // the gcd unit only runs during the load sweep
    a_gcd_idle_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TREAD || state_reg == S_TEVAL || state_reg == S_PUSH
         || state_reg == S_FINISH) |-> !gcd_busy)
        else $error("gcd unit busy during tick scan");

    // an in-bank load always starts the gcd sweep
    a_load_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        load_hit |=> (state_reg == S_GREAD))
        else $error("load did not start gcd sweep");

    // the flushed firing carries the last flag
    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && pend_valid_reg && slot_free)
        |=> (rsp_valid && rsp_data.last && rsp_data.kind == KIND_FIRE))
        else $error("final firing without last flag");

    // a held firing is always counted
    a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (count_reg != '0 && count_reg <= CW'(MAX_RESULTS)))
        else $error("pending firing count out of range");
`endif

endmodule

`default_nettype wire
